// File: hw/rtl/pme_pkg.sv
// Shared types and constants for the POCSAG message encoder.
// No dependencies; every other file of the block imports this package.
package pme_pkg;

  // Fixed codeword constants of the paging format.
  localparam logic [31:0] SYNC_WORD = 32'h7CD2_15D8;
  localparam logic [31:0] IDLE_WORD = 32'h7A89_C197;
  localparam logic [31:0] DATA_MASK = 32'hFFFF_F800;
  localparam logic [10:0] BCH_POLY = 11'h769;

  // Numeric pad pattern: the space code 0011 repeated, first bit at the MSB.
  localparam logic [19:0] NUM_PAD_PATTERN = 20'h33333;
  localparam logic [3:0] NUM_SPACE = 4'hC;
  localparam logic [6:0] ALPHA_MASK = 7'h7F;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PAGER_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_FUNCTION_CODE = 2'd1;
  localparam logic [1:0] CFG_ALPHA_MODE = 2'd2;

  // Which codeword the datapath builds for the BCH unit.
  typedef enum logic [2:0] {
    WORD_SYNC,
    WORD_IDLE,
    WORD_ADDR,
    WORD_MSG,
    WORD_PAD
  } word_kind_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_CHAR,
    ST_PAD,
    ST_FILL0,
    ST_FILL,
    ST_BUSY,
    ST_DRAIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       append;
    logic       emit;
    word_kind_t kind;
    logic       commit;
    logic       drain;
    logic       finish;
  } pme_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic address_sent;
    logic sync_pending;
    logic slot_at_target;
    logic slot_zero;
    logic item_valid;
    logic item_last;
    logic char_fills;
    logic pb_nonzero;
    logic bch_done;
    logic held_valid;
    logic out_free;
  } pme_status_t;

endpackage

// File: hw/rtl/pme_bch.sv
// BCH(31,21) check bit and even parity unit, seven divider steps per cycle.
// Depends on pme_pkg for the generator polynomial and the data mask.
module pme_bch (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] data_in,
  output logic        done,
  output logic [31:0] result
);
  import pme_pkg::*;

  logic [31:0] data;
  logic [31:0] sr;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] pre;

  // Seven steps of the shift-register division.
  function automatic logic [31:0] step7(input logic [31:0] v);
    logic [31:0] s;
    s = v;
    for (int k = 0; k < 7; k++) begin
      if (s[31]) begin
        s = s ^ {BCH_POLY, 21'b0};
      end
      s = s << 1;
    end
    return s;
  endfunction

  // Division runs while busy after start; done rises when it ends and holds until the next start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= 2'd0;
    end else if (busy) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd2) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      data <= data_in & DATA_MASK;
      sr <= data_in & DATA_MASK;
    end else if (busy) begin
      sr <= step7(sr);
    end
  end

  // Check bits join the data, then parity makes the word even.
  assign pre = data | {21'b0, sr[31:21]};
  assign result = pre | {31'b0, ^pre};

endmodule

// File: hw/rtl/pme_datapath.sv
// Datapath of the POCSAG encoder: configuration, message state, word builder,
// hold and output registers. Depends on pme_pkg and instantiates pme_bch.
module pme_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [1:0]           cfg_index,
  input  logic [20:0]          cfg_data,
  input  logic [7:0]           character,
  input  logic                 char_valid,
  input  logic                 message_last,
  input  logic                 out_stall,
  input  pme_pkg::pme_cmd_t    cmd,
  output pme_pkg::pme_status_t status,
  output logic                 out_valid,
  output logic [31:0]          codeword,
  output logic                 run_last,
  output logic                 transmission_end
);
  import pme_pkg::*;

  // Configuration registers.
  logic [20:0] pager_address;
  logic [1:0]  func_code;
  logic        alpha_mode;

  // Message state.
  logic [19:0] payload_accum;
  logic [4:0]  payload_bits;
  logic [3:0]  slot_index;
  logic        sync_pending;
  logic        address_sent;

  // Captured item.
  logic [7:0] item_char;
  logic       item_valid;
  logic       item_last;

  // Hold register keeps one word back so the final flag can be set.
  logic        held_valid;
  logic [31:0] held_word;

  logic        bch_done;
  logic [31:0] bch_result;
  logic [31:0] raw_word;

  logic [3:0]  num_code;
  logic [6:0]  alpha_bits;
  logic [6:0]  chunk;
  logic [2:0]  chunk_len;
  logic [26:0] joined;
  logic [4:0]  total;
  logic [2:0]  spill;
  logic [26:0] shifted;
  logic [19:0] msg_payload;
  logic [19:0] rem_bits;
  logic [4:0]  pad_len;
  logic [19:0] pad_payload;
  logic        out_free;

  // Numeric character code.
  function automatic logic [3:0] numeric_code(input logic [7:0] c);
    logic [3:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = c[3:0];
    end else if (c == 8'h55) begin
      r = 4'hB;
    end else if (c == 8'h20) begin
      r = NUM_SPACE;
    end else if (c == 8'h2D) begin
      r = 4'hD;
    end else if (c == 8'h5D) begin
      r = 4'hE;
    end else if (c == 8'h5B) begin
      r = 4'hF;
    end else begin
      r = 4'hA;
    end
    return r;
  endfunction

  // Character bits in send order, first bit at the top of the chunk.
  always_comb begin
    num_code = numeric_code(item_char);
    alpha_bits = item_char[6:0] & ALPHA_MASK;
    if (alpha_mode) begin
      chunk = {alpha_bits[0], alpha_bits[1], alpha_bits[2], alpha_bits[3],
               alpha_bits[4], alpha_bits[5], alpha_bits[6]};
      chunk_len = 3'd7;
    end else begin
      chunk = {3'b0, num_code[0], num_code[1], num_code[2], num_code[3]};
      chunk_len = 3'd4;
    end
  end

  // Append the chunk; when 20 bits are reached the top 20 form the word.
  always_comb begin
    joined = ({7'b0, payload_accum} << chunk_len) | {20'b0, chunk};
    total = payload_bits + {2'b0, chunk_len};
    spill = 3'(total - 5'd20);
    shifted = joined >> spill;
    msg_payload = shifted[19:0];
    rem_bits = joined[19:0] & ((20'd1 << spill) - 20'd1);
  end

  // Flush padding: zeros in alpha mode, repeated spaces in numeric mode.
  always_comb begin
    pad_len = 5'd20 - payload_bits;
    pad_payload = payload_accum << pad_len;
    if (!alpha_mode) begin
      pad_payload = pad_payload | (NUM_PAD_PATTERN & ((20'd1 << pad_len) - 20'd1));
    end
  end

  // Word handed to the BCH unit.
  always_comb begin
    unique case (cmd.kind)
      WORD_SYNC: raw_word = SYNC_WORD;
      WORD_IDLE: raw_word = IDLE_WORD;
      WORD_ADDR: raw_word = {1'b0, pager_address[20:3], func_code, 11'b0};
      WORD_MSG:  raw_word = {1'b1, msg_payload, 11'b0};
      WORD_PAD:  raw_word = {1'b1, pad_payload, 11'b0};
      default:   raw_word = IDLE_WORD;
    endcase
  end

  pme_bch u_bch (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.emit),
    .data_in (raw_word),
    .done    (bch_done),
    .result  (bch_result)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pager_address <= 21'd8;
      func_code <= 2'd0;
      alpha_mode <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_PAGER_ADDRESS: pager_address <= cfg_data;
        CFG_FUNCTION_CODE: func_code <= cfg_data[1:0];
        CFG_ALPHA_MODE:    alpha_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_char <= character;
      item_valid <= char_valid;
      item_last <= message_last;
    end
  end

  // Message state; slot side effects are taken when a word is issued.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      payload_accum <= 20'd0;
      payload_bits <= 5'd0;
      slot_index <= 4'd0;
      sync_pending <= 1'b1;
      address_sent <= 1'b0;
    end else if (cmd.append) begin
      payload_accum <= joined[19:0];
      payload_bits <= total;
    end else if (cmd.emit) begin
      if (cmd.kind == WORD_SYNC) begin
        sync_pending <= 1'b0;
      end else begin
        slot_index <= slot_index + 4'd1;
        if (slot_index == 4'd15) begin
          sync_pending <= 1'b1;
        end
      end
      if (cmd.kind == WORD_ADDR) begin
        address_sent <= 1'b1;
      end
      if (cmd.kind == WORD_MSG) begin
        payload_accum <= rem_bits;
        payload_bits <= {2'b0, spill};
      end
      if (cmd.kind == WORD_PAD) begin
        payload_accum <= 20'd0;
        payload_bits <= 5'd0;
      end
    end
  end

  // Hold register and output register.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        held_valid <= 1'b1;
      end else if (cmd.drain) begin
        held_valid <= 1'b0;
      end
      if ((cmd.commit && held_valid) || cmd.drain) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      held_word <= bch_result;
    end
    if (cmd.commit && held_valid) begin
      codeword <= held_word;
      run_last <= 1'b0;
      transmission_end <= 1'b0;
    end else if (cmd.drain) begin
      codeword <= held_word;
      run_last <= 1'b1;
      transmission_end <= item_last;
    end
  end

  // Status to the controller.
  always_comb begin
    status.address_sent = address_sent;
    status.sync_pending = sync_pending;
    status.slot_at_target = (slot_index == {pager_address[2:0], 1'b0});
    status.slot_zero = (slot_index == 4'd0);
    status.item_valid = item_valid;
    status.item_last = item_last;
    status.char_fills = (total >= 5'd20);
    status.pb_nonzero = (payload_bits != 5'd0);
    status.bch_done = bch_done;
    status.held_valid = held_valid;
    status.out_free = out_free;
  end

endmodule

// File: hw/rtl/pme_ctrl.sv
// Controller state machine of the POCSAG encoder: sequences lead-in words,
// character words, padding and batch fill. Depends on pme_pkg.
module pme_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pme_pkg::pme_status_t status,
  output pme_pkg::pme_cmd_t    cmd
);
  import pme_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;

  // State and return registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= ST_IDLE;
    end else begin
      state <= state_next;
      ret <= ret_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    ret_next = ret;
    cmd = '0;
    cmd.kind = WORD_IDLE;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = ST_LEAD;
        end
      end
      // Sync, idles up to the address slot, then the address word.
      ST_LEAD: begin
        if (status.address_sent) begin
          state_next = ST_CHAR;
        end else begin
          cmd.emit = 1'b1;
          if (status.sync_pending) begin
            cmd.kind = WORD_SYNC;
          end else if (!status.slot_at_target) begin
            cmd.kind = WORD_IDLE;
          end else begin
            cmd.kind = WORD_ADDR;
          end
          ret_next = ST_LEAD;
          state_next = ST_BUSY;
        end
      end
      // Append the character, issuing a message word when it fills one.
      ST_CHAR: begin
        if (!status.item_valid) begin
          state_next = ST_PAD;
        end else if (!status.char_fills) begin
          cmd.append = 1'b1;
          state_next = ST_PAD;
        end else begin
          cmd.emit = 1'b1;
          state_next = ST_BUSY;
          if (status.sync_pending) begin
            cmd.kind = WORD_SYNC;
            ret_next = ST_CHAR;
          end else begin
            cmd.kind = WORD_MSG;
            ret_next = ST_PAD;
          end
        end
      end
      // At message end, pad and send a partly filled word.
      ST_PAD: begin
        if (!status.item_last) begin
          state_next = ST_DRAIN;
        end else if (status.pb_nonzero) begin
          cmd.emit = 1'b1;
          cmd.kind = status.sync_pending ? WORD_SYNC : WORD_PAD;
          ret_next = ST_PAD;
          state_next = ST_BUSY;
        end else begin
          state_next = ST_FILL0;
        end
      end
      // First fill word always goes out; it opens a new batch if due.
      ST_FILL0: begin
        cmd.emit = 1'b1;
        cmd.kind = status.sync_pending ? WORD_SYNC : WORD_IDLE;
        ret_next = status.sync_pending ? ST_FILL0 : ST_FILL;
        state_next = ST_BUSY;
      end
      // Remaining idles up to the end of the batch.
      ST_FILL: begin
        if (status.slot_zero) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.emit = 1'b1;
          cmd.kind = WORD_IDLE;
          ret_next = ST_FILL;
          state_next = ST_BUSY;
        end
      end
      // Wait for the BCH unit and room to move the held word on.
      ST_BUSY: begin
        if (status.bch_done && (!status.held_valid || status.out_free)) begin
          cmd.commit = 1'b1;
          state_next = ret;
        end
      end
      // Release the held word as the last of this request.
      ST_DRAIN: begin
        if (!status.held_valid) begin
          cmd.finish = status.item_last;
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.drain = 1'b1;
          cmd.finish = status.item_last;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/pocsag_message_encoder_top.sv
// Top level of the POCSAG message encoder.
// Depends on pme_pkg; instantiates pme_ctrl and pme_datapath.
//
// Usage: message characters arrive on the input channel (in_valid/in_stall)
// as one request each, with char_valid and message_last. The block returns
// 32-bit codewords on the output channel (out_valid/out_stall) in send
// order: sync words, idle fill, the address word, message words with BCH
// check bits and even parity. run_last marks the last codeword caused by a
// request and transmission_end the last codeword of a message.
// Configuration (pager address, function code, alpha mode) is written on
// cfg_write_en/cfg_index/cfg_data between messages.
// Codewords are made one at a time: the controller issues a word, the BCH
// divider runs seven division steps per cycle, and the word is retired
// before the next is issued. One codeword waits in a hold register until the
// next is made, so the final flags are known when it is released.
// A stalled receiver backs up into the hold register and the controller
// waits; no codeword is lost. Reset clears the message state, loads the
// default configuration (address 8, function 0, numeric) and empties the
// output.
module pocsag_message_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  input  logic        char_valid,
  input  logic        message_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] codeword,
  output logic        run_last,
  output logic        transmission_end,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);
  import pme_pkg::*;

  pme_cmd_t    cmd;
  pme_status_t status;

  pme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pme_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .character        (character),
    .char_valid       (char_valid),
    .message_last     (message_last),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .codeword         (codeword),
    .run_last         (run_last),
    .transmission_end (transmission_end)
  );

endmodule

// File: sim/pocsag_message_encoder_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for pocsag_message_encoder_top: a directed table, then random messages,
// checked against a behavioral codeword encoder. Depends on pme_pkg and the block's RTL only.
module pocsag_message_encoder_top_tb;
  import pme_pkg::*;

  localparam int RANDOM_ITEMS = 405;
  localparam int SETTLE_CYCLES = 32;
  localparam int WATCHDOG_LIMIT = 2000;

  // One row of the directed table: a request or a register write.
  typedef enum logic {
    ROW_REQUEST,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  ch;
    logic        cv;
    logic        ml;
    logic        opens_with_sync;
    logic [1:0]  reg_index;
    logic [20:0] reg_value;
  } stim_row_t;

  // One codeword with its flags.
  typedef struct packed {
    logic [31:0] codeword;
    logic        run_last;
    logic        transmission_end;
  } codeword_rec_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_mode_t;

  // Characters that have a numeric code of their own.
  localparam logic [7:0] NUMERIC_CHARS [0:14] = '{
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9", "U", " ", "-", "]", "["
  };

  // Directed part: default registers, every numeric symbol but 6, alphanumeric flush,
  // a final word in the last slot, start-only request and mode changes mid-message.
  localparam stim_row_t DIRECTED_ROWS [0:35] = '{
    '{ROW_REQUEST, "1", 1'b1, 1'b0, 1'b1, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "9", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "U", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, " ", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "-", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "]", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "[", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, 8'h00, 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, 8'hFF, 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, 8'h00, 1'b0, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "0", 1'b1, 1'b1, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'h1FFFFF},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_FUNCTION_CODE, 21'd3},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_ALPHA_MODE, 21'd1},
    '{ROW_REQUEST, "A", 1'b1, 1'b0, 1'b1, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, 8'hFF, 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, 8'h00, 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, 8'hA5, 1'b0, 1'b1, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_ALPHA_MODE, 21'd0},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd7},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_FUNCTION_CODE, 21'd1},
    '{ROW_REQUEST, "1", 1'b1, 1'b0, 1'b1, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "2", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "3", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "4", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "5", 1'b1, 1'b1, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_FUNCTION_CODE, 21'd2},
    '{ROW_REQUEST, 8'h00, 1'b0, 1'b0, 1'b1, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "7", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_ALPHA_MODE, 21'd1},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd5},
    '{ROW_REQUEST, "z", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_REQUEST, "3", 1'b1, 1'b0, 1'b0, CFG_PAGER_ADDRESS, 21'd0},
    '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, CFG_ALPHA_MODE, 21'd0},
    '{ROW_REQUEST, "8", 1'b1, 1'b1, 1'b0, CFG_PAGER_ADDRESS, 21'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  character = 8'd0;
  logic        char_valid = 1'b0;
  logic        message_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] codeword;
  logic        run_last;
  logic        transmission_end;
  logic        cfg_write_en = 1'b0;
  logic [1:0]  cfg_index = CFG_PAGER_ADDRESS;
  logic [20:0] cfg_data = 21'd0;

  pocsag_message_encoder_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .character        (character),
    .char_valid       (char_valid),
    .message_last     (message_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .codeword         (codeword),
    .run_last         (run_last),
    .transmission_end (transmission_end),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Encoder copy of the registers and the message state.
  logic [20:0] pager_addr_q = 21'd8;
  logic [1:0]  func_code_q = 2'd0;
  logic        alpha_q = 1'b0;
  logic [19:0] payload_q = 20'd0;
  int          payload_count = 0;
  logic [3:0]  next_slot = 4'd0;
  logic        sync_due = 1'b1;
  logic        address_done = 1'b0;

  codeword_rec_t expected_words [$];
  int            error_count = 0;
  int            burst_left = 0;

  // BCH(31,21) check bits over bits 31..11, then even parity in bit 0.
  function automatic logic [31:0] bch_encode(input logic [31:0] w);
    logic [31:0] data;
    logic [31:0] rem;
    data = w & DATA_MASK;
    rem = data;
    for (int k = 0; k < 21; k++) begin
      if (rem[31]) rem = rem ^ {BCH_POLY, 21'd0};
      rem = rem << 1;
    end
    data = data | (rem >> 21);
    return data | {31'd0, ^data};
  endfunction

  // Puts a word in the next slot, opening the batch with a sync word when due.
  function automatic void place_word(input logic [31:0] w);
    codeword_rec_t rec;
    rec = '0;
    if (sync_due) begin
      rec.codeword = bch_encode(SYNC_WORD);
      expected_words.push_back(rec);
      sync_due = 1'b0;
    end
    rec.codeword = bch_encode(w);
    expected_words.push_back(rec);
    next_slot = next_slot + 4'd1;
    if (next_slot == 4'd0) sync_due = 1'b1;
  endfunction

  function automatic void shift_payload(input logic b);
    payload_q = {payload_q[18:0], b};
    payload_count++;
    if (payload_count >= 20) begin
      place_word({1'b1, payload_q, 11'd0});
      payload_q = '0;
      payload_count = 0;
    end
  endfunction

  function automatic logic [3:0] numeric_code(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return ch[3:0];
    case (ch)
      "U": return 4'hB;
      " ": return NUM_SPACE;
      "-": return 4'hD;
      "]": return 4'hE;
      "[": return 4'hF;
      default: return 4'hA;
    endcase
  endfunction

  // Appends the codewords that one request produces, with their flags.
  function automatic void encode_request(input logic [7:0] ch, input logic cv, input logic ml);
    int          head;
    logic [3:0]  target;
    logic [3:0]  code;
    head = expected_words.size();
    if (!address_done) begin
      target = {pager_addr_q[2:0], 1'b0};
      while (next_slot != target) place_word(IDLE_WORD);
      place_word({1'b0, pager_addr_q[20:3], func_code_q, 11'd0});
      address_done = 1'b1;
    end
    if (cv) begin
      if (alpha_q) begin
        for (int k = 0; k < 7; k++) shift_payload(ch[k]);
      end else begin
        code = numeric_code(ch);
        for (int k = 0; k < 4; k++) shift_payload(code[k]);
      end
    end
    if (ml) begin
      // Pad the open word: zeros in alphanumeric mode, repeated spaces in numeric mode.
      while (payload_count > 0) shift_payload(alpha_q ? 1'b0 : ((payload_count % 4) >= 2));
      if (next_slot != 4'd0) begin
        while (next_slot != 4'd0) place_word(IDLE_WORD);
      end else begin
        for (int k = 0; k < 16; k++) place_word(IDLE_WORD);
      end
      payload_q = '0;
      payload_count = 0;
      next_slot = 4'd0;
      sync_due = 1'b1;
      address_done = 1'b0;
    end
    if (expected_words.size() > head) begin
      expected_words[expected_words.size() - 1].run_last = 1'b1;
      expected_words[expected_words.size() - 1].transmission_end = ml;
    end
  endfunction

  // Sends one request in bursts separated by random gaps.
  task automatic send_request(input logic [7:0] ch, input logic cv, input logic ml,
                              input logic opens_with_sync);
    int head;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    character <= ch;
    char_valid <= cv;
    message_last <= ml;
    do @(posedge clk); while (in_stall);
    head = expected_words.size();
    encode_request(ch, cv, ml);
    // A fresh message always opens with the sync word.
    if (opens_with_sync) expected_words[head].codeword = SYNC_WORD;
  endtask

  // Lets the block finish all work before a register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_PAGER_ADDRESS: pager_addr_q = val;
      CFG_FUNCTION_CODE: func_code_q = val[1:0];
      CFG_ALPHA_MODE: alpha_q = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_character();
    if (!alpha_q && $urandom_range(0, 3) != 0) return NUMERIC_CHARS[$urandom_range(0, 14)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [20:0] pick_address();
    case ($urandom_range(0, 3))
      0: return 21'd0;
      1: return 21'h1FFFFF;
      default: return 21'($urandom_range(0, 21'h1FFFFF));
    endcase
  endfunction

  // Receiver stall pattern: no stalls, random stalls or a fixed duty cycle, in phases.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_phase_left = 0;
  int          stall_tick = 0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_phase_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_phase_left <= $urandom_range(50, 400);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
      default: out_stall <= 1'b0;
    endcase
  end

  // Compare each accepted codeword with the oldest expectation.
  always @(posedge clk) begin
    codeword_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("codeword: none expected, got %h", codeword);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (codeword !== want.codeword) begin
          $error("codeword: expected %h, got %h", want.codeword, codeword);
          error_count++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, run_last);
          error_count++;
        end
        if (transmission_end !== want.transmission_end) begin
          $error("transmission_end: expected %b, got %b", want.transmission_end,
                 transmission_end);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no request and no codeword accepted.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pocsag_message_encoder_top_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: reset, directed table, then random messages.
  initial begin
    int         items_sent;
    int         msg_len;
    int         switch_at;
    logic       ml;
    logic       cv;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(DIRECTED_ROWS[r].reg_index, DIRECTED_ROWS[r].reg_value);
      end else begin
        send_request(DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].cv, DIRECTED_ROWS[r].ml,
                     DIRECTED_ROWS[r].opens_with_sync);
      end
    end

    while (items_sent < RANDOM_ITEMS) begin
      // New register settings between some messages.
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        write_reg(CFG_PAGER_ADDRESS, pick_address());
        write_reg(CFG_FUNCTION_CODE, 21'($urandom_range(0, 3)));
        write_reg(CFG_ALPHA_MODE, 21'($urandom_range(0, 1)));
      end
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      switch_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : -1;
      for (int i = 0; i < msg_len; i++) begin
        // Occasional mode change, and an address change that must not take effect.
        if (i == switch_at) begin
          wait_idle();
          write_reg(CFG_ALPHA_MODE, 21'($urandom_range(0, 1)));
          if ($urandom_range(0, 1) == 0) write_reg(CFG_PAGER_ADDRESS, pick_address());
        end
        ml = (i == msg_len - 1);
        cv = ml ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) != 0);
        items_sent++;
        send_request(pick_character(), cv, ml, 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("pocsag_message_encoder_top_tb: done, clean");
    end else begin
      $display("pocsag_message_encoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
